>>> design/process_scheduler_policies_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the process scheduler
// Shared concurrent-check forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PROCESS_SCHEDULER_POLICIES_ASSERT_SVH
`define PROCESS_SCHEDULER_POLICIES_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Sizes, codes and helpers shared by the process scheduler modules.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int TIME_W  = 24;
	localparam int QUANT_W = 16;
	localparam int QCNT_W  = $clog2(QUANT_W);
	localparam int POL_W   = 2;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd500;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	typedef enum logic [POL_W-1:0] {
		POL_FIFO = 2'd0,
		POL_RR   = 2'd1,
		POL_SJF  = 2'd2,
		POL_PSJF = 2'd3
	} policy_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MOD   = 10'b00_0000_0010,
		ST_DISP  = 10'b00_0000_0100,
		ST_SCAN  = 10'b00_0000_1000,
		ST_POP   = 10'b00_0001_0000,
		ST_PWAIT = 10'b00_0010_0000,
		ST_PCHK  = 10'b00_0100_0000,
		ST_RUN   = 10'b00_1000_0000,
		ST_RWAIT = 10'b01_0000_0000,
		ST_UPD   = 10'b10_0000_0000
	} state_t;

	// Advance a ring pointer, wrapping at the slot count.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] ptr);
		if (ptr == SLOT_W'(SLOTS - 1)) begin
			return '0;
		end
		return ptr + SLOT_W'(1);
	endfunction

endpackage

>>> design/psp_ram.sv
// ----------------------------------------------------------------------------
// psp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/process_scheduler_policies.sv
// ----------------------------------------------------------------------------
// process_scheduler_policies
// Time-stepped job scheduler with FIFO, round robin, SJF and PSJF policies.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/command/burst_length and transfer at a clock
//   edge with start high and busy low. Every command yields one result,
//   shown for one cycle with done high; the receiver cannot stall it.
//   An arrive stores the burst in the next slot and joins the round-robin
//   ring; busy stays low and the result follows in the next cycle.
//   A tick raises busy, picks a job, takes one unit off its remaining time
//   and reports it. Remaining times sit in a 16x24 RAM, the ring in a 16x4
//   RAM, both with a registered read port; one read per cycle sets the rate.
//   A tick passes through dispatch, then for FIFO/SJF/PSJF a scan of every
//   arrived slot, or a read of the running job when it is kept; a round-robin
//   rotation pops ring entries one at a time until a live one is found, and
//   when the ring runs dry the tick idles or the running job stays. Each
//   tick ends in the update state. A slice count at or above a freshly
//   lowered quantum first runs a bit-serial remainder before the pick.
//   The APB port sets policy (0x0) and quantum (0x4); write only while idle.
//   Reset empties the job table, selects FIFO and a quantum of 500; no
//   clearing pass is needed, busy is low right after reset.
// ----------------------------------------------------------------------------
`include "process_scheduler_policies_assert.svh"

module process_scheduler_policies (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [psp_pkg::TIME_W-1:0]           burst_length,
	// result channel
	output logic                                 done,
	output logic                                 status,
	output logic [psp_pkg::SLOT_W-1:0]           arrived_slot,
	output logic                                 run_valid,
	output logic [psp_pkg::SLOT_W-1:0]           run_slot,
	output logic                                 job_finished,
	output logic                                 context_switch,
	output logic [psp_pkg::CNT_W-1:0]            finished_total,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [psp_pkg::ADDR_W-1:0]           paddr,
	input  logic [psp_pkg::DATA_W-1:0]           pwdata,
	output logic [psp_pkg::DATA_W-1:0]           prdata,
	output logic                                 pready
);

	localparam int SW = psp_pkg::SLOT_W;
	localparam int CW = psp_pkg::CNT_W;
	localparam int TW = psp_pkg::TIME_W;
	localparam int QW = psp_pkg::QUANT_W;

	// configuration registers
	psp_pkg::policy_t policy_q;
	logic [QW-1:0]    quantum_q;
	logic [QW-1:0]    q_eff;
	logic             cfg_wr;

	// scheduler state
	psp_pkg::state_t  state_q;
	logic [CW-1:0]    arrived_q;
	logic [CW-1:0]    finished_q;
	logic [SW-1:0]    head_q;
	logic [SW-1:0]    tail_q;
	logic [CW-1:0]    ring_cnt_q;
	logic             run_vld_q;
	logic [SW-1:0]    run_slot_q;
	logic [QW-1:0]    slice_q;

	// per-tick working registers
	logic [QW-1:0]    rem_q;
	logic [QW-1:0]    div_q;
	logic [psp_pkg::QCNT_W-1:0] mod_cnt_q;
	logic [CW-1:0]    cnt_q;
	logic             sv_s1;
	logic [SW-1:0]    sidx_s1;
	logic             pick_vld_q;
	logic [SW-1:0]    pick_slot_q;
	logic [TW-1:0]    pick_val_q;
	logic [SW-1:0]    pe_q;

	// result registers
	logic             done_q;
	logic             status_q;
	logic [SW-1:0]    arr_slot_q;
	logic             res_run_q;
	logic [SW-1:0]    res_slot_q;
	logic             res_fin_q;
	logic             res_cs_q;
	logic [CW-1:0]    res_total_q;

	// RAM ports
	logic             rt_we;
	logic [SW-1:0]    rt_waddr;
	logic [TW-1:0]    rt_wdata;
	logic [SW-1:0]    rt_raddr;
	logic [TW-1:0]    rt_rdata;
	logic             rg_we;
	logic [SW-1:0]    rg_waddr;
	logic [SW-1:0]    rg_wdata;
	logic [SW-1:0]    rg_rdata;

	// decode
	logic             accept;
	logic             arrive_go;
	logic             arr_ok;
	logic             ring_room;
	logic [QW:0]      mod_t;
	logic             mod_ge;
	logic [QW-1:0]    mod_next;
	logic             scan_issue;
	logic             scan_take;
	logic             pop_live;
	logic             upd_run;
	logic [TW-1:0]    upd_val;
	logic             upd_fin;
	logic             upd_same;
	logic [QW-1:0]    slice_inc;
	logic [QW-1:0]    slice_first;
	logic             push_rot;

	assign busy   = (state_q != psp_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign q_eff  = (quantum_q == '0) ? QW'(1) : quantum_q;

	always_comb begin
		if (paddr[2] == psp_pkg::REG_QUANTUM) begin
			prdata = psp_pkg::DATA_W'(quantum_q);
		end else begin
			prdata = psp_pkg::DATA_W'(policy_q);
		end
	end

	assign arr_ok    = (arrived_q < CW'(psp_pkg::SLOTS));
	assign ring_room = (ring_cnt_q < CW'(psp_pkg::SLOTS));
	assign arrive_go = accept && (command == psp_pkg::CMD_ARRIVE) && arr_ok;

	// one bit of restoring remainder per cycle
	assign mod_t    = {rem_q, div_q[QW-1]};
	assign mod_ge   = (mod_t >= {1'b0, q_eff});
	assign mod_next = mod_ge ? QW'(mod_t - {1'b0, q_eff}) : mod_t[QW-1:0];

	// linear scan: first live slot for FIFO, strict minimum otherwise
	assign scan_issue = (cnt_q < arrived_q);
	assign scan_take  = sv_s1 && (rt_rdata != '0) &&
		(!pick_vld_q || (policy_q != psp_pkg::POL_FIFO && rt_rdata < pick_val_q));

	assign pop_live = (CW'(pe_q) < arrived_q) && (rt_rdata != '0);
	assign push_rot = (state_q == psp_pkg::ST_PCHK) && pop_live && run_vld_q && ring_room;

	assign upd_run     = pick_vld_q && (pick_val_q != '0);
	assign upd_val     = pick_val_q - TW'(1);
	assign upd_fin     = (upd_val == '0);
	assign upd_same    = run_vld_q && (pick_slot_q == run_slot_q);
	assign slice_inc   = ({1'b0, rem_q} + (QW+1)'(1) == {1'b0, q_eff}) ? '0 : rem_q + QW'(1);
	assign slice_first = (q_eff == QW'(1)) ? '0 : QW'(1);

	// remaining-time RAM: write on arrival or on the tick update
	always_comb begin
		rt_we    = 1'b0;
		rt_waddr = pick_slot_q;
		rt_wdata = upd_val;
		if (arrive_go) begin
			rt_we    = 1'b1;
			rt_waddr = arrived_q[SW-1:0];
			rt_wdata = (burst_length == '0) ? TW'(1) : burst_length;
		end else if (state_q == psp_pkg::ST_UPD) begin
			rt_we = upd_run;
		end
	end

	always_comb begin
		case (state_q)
			psp_pkg::ST_SCAN:  rt_raddr = cnt_q[SW-1:0];
			psp_pkg::ST_PWAIT: rt_raddr = rg_rdata;
			default:           rt_raddr = run_slot_q;
		endcase
	end

	// ring RAM: append the new slot or the rotated-out job at the tail
	always_comb begin
		rg_we    = 1'b0;
		rg_waddr = tail_q;
		rg_wdata = run_slot_q;
		if (arrive_go) begin
			rg_we    = ring_room;
			rg_wdata = arrived_q[SW-1:0];
		end else if (push_rot) begin
			rg_we = 1'b1;
		end
	end

	psp_ram #(.WIDTH(TW), .DEPTH(psp_pkg::SLOTS)) u_time_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (rt_waddr),
		.wdata (rt_wdata),
		.raddr (rt_raddr),
		.rdata (rt_rdata)
	);

	psp_ram #(.WIDTH(SW), .DEPTH(psp_pkg::SLOTS)) u_ring_ram (
		.clk   (clk),
		.we    (rg_we),
		.waddr (rg_waddr),
		.wdata (rg_wdata),
		.raddr (head_q),
		.rdata (rg_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= psp_pkg::POL_FIFO;
			quantum_q <= psp_pkg::QUANTUM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == psp_pkg::REG_QUANTUM) begin
				quantum_q <= pwdata[QW-1:0];
			end else begin
				policy_q <= psp_pkg::policy_t'(pwdata[psp_pkg::POL_W-1:0]);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psp_pkg::ST_IDLE;
			arrived_q   <= '0;
			finished_q  <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			ring_cnt_q  <= '0;
			run_vld_q   <= 1'b0;
			run_slot_q  <= '0;
			slice_q     <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			mod_cnt_q   <= '0;
			cnt_q       <= '0;
			sv_s1       <= 1'b0;
			sidx_s1     <= '0;
			pick_vld_q  <= 1'b0;
			pick_slot_q <= '0;
			pick_val_q  <= '0;
			pe_q        <= '0;
			done_q      <= 1'b0;
			status_q    <= 1'b0;
			arr_slot_q  <= '0;
			res_run_q   <= 1'b0;
			res_slot_q  <= '0;
			res_fin_q   <= 1'b0;
			res_cs_q    <= 1'b0;
			res_total_q <= '0;
		end else begin
			// strobe a result after an arrival transfer or at the end of a tick
			done_q <= (accept && command == psp_pkg::CMD_ARRIVE) ||
				(state_q == psp_pkg::ST_UPD);

			// ring tail moves on arrival or on a rotation push
			if ((arrive_go && ring_room) || push_rot) begin
				tail_q     <= psp_pkg::next_slot(tail_q);
				ring_cnt_q <= ring_cnt_q + CW'(1);
			end

			case (state_q)
				psp_pkg::ST_IDLE: begin
					if (accept && command == psp_pkg::CMD_ARRIVE) begin
						// answer an arrival in the next cycle
						status_q    <= !arr_ok;
						arr_slot_q  <= arr_ok ? arrived_q[SW-1:0] : '0;
						res_run_q   <= 1'b0;
						res_slot_q  <= '0;
						res_fin_q   <= 1'b0;
						res_cs_q    <= 1'b0;
						res_total_q <= finished_q;
						if (arr_ok) begin
							arrived_q <= arrived_q + CW'(1);
						end
					end else if (accept) begin
						pick_vld_q <= 1'b0;
						if (run_vld_q && slice_q >= q_eff) begin
							// reduce the slice count under a lowered quantum
							rem_q     <= '0;
							div_q     <= slice_q;
							mod_cnt_q <= psp_pkg::QCNT_W'(QW - 1);
							state_q   <= psp_pkg::ST_MOD;
						end else begin
							rem_q   <= slice_q;
							state_q <= psp_pkg::ST_DISP;
						end
					end
				end

				psp_pkg::ST_MOD: begin
					rem_q     <= mod_next;
					div_q     <= {div_q[QW-2:0], 1'b0};
					mod_cnt_q <= mod_cnt_q - psp_pkg::QCNT_W'(1);
					if (mod_cnt_q == '0) begin
						state_q <= psp_pkg::ST_DISP;
					end
				end

				psp_pkg::ST_DISP: begin
					cnt_q <= '0;
					sv_s1 <= 1'b0;
					case (policy_q)
						psp_pkg::POL_FIFO,
						psp_pkg::POL_SJF: begin
							state_q <= run_vld_q ? psp_pkg::ST_RUN : psp_pkg::ST_SCAN;
						end
						psp_pkg::POL_RR: begin
							// keep the job inside its slice, else rotate
							if (run_vld_q && rem_q != '0) begin
								state_q <= psp_pkg::ST_RUN;
							end else begin
								state_q <= psp_pkg::ST_POP;
							end
						end
						default: begin
							state_q <= psp_pkg::ST_SCAN;
						end
					endcase
				end

				psp_pkg::ST_SCAN: begin
					sv_s1   <= scan_issue;
					sidx_s1 <= cnt_q[SW-1:0];
					if (scan_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (scan_take) begin
						pick_vld_q  <= 1'b1;
						pick_slot_q <= sidx_s1;
						pick_val_q  <= rt_rdata;
					end
					if (!scan_issue && !sv_s1) begin
						state_q <= psp_pkg::ST_UPD;
					end
				end

				psp_pkg::ST_POP: begin
					if (ring_cnt_q == '0) begin
						// nothing live: a rotating job stays, else idle
						state_q <= run_vld_q ? psp_pkg::ST_RUN : psp_pkg::ST_UPD;
					end else begin
						head_q     <= psp_pkg::next_slot(head_q);
						ring_cnt_q <= ring_cnt_q - CW'(1);
						state_q    <= psp_pkg::ST_PWAIT;
					end
				end

				psp_pkg::ST_PWAIT: begin
					pe_q    <= rg_rdata;
					state_q <= psp_pkg::ST_PCHK;
				end

				psp_pkg::ST_PCHK: begin
					if (pop_live) begin
						pick_vld_q  <= 1'b1;
						pick_slot_q <= pe_q;
						pick_val_q  <= rt_rdata;
						state_q     <= psp_pkg::ST_UPD;
					end else begin
						// drop a finished entry and try the next
						state_q <= psp_pkg::ST_POP;
					end
				end

				psp_pkg::ST_RUN: begin
					state_q <= psp_pkg::ST_RWAIT;
				end

				psp_pkg::ST_RWAIT: begin
					pick_vld_q  <= 1'b1;
					pick_slot_q <= run_slot_q;
					pick_val_q  <= rt_rdata;
					state_q     <= psp_pkg::ST_UPD;
				end

				psp_pkg::ST_UPD: begin
					status_q   <= 1'b0;
					arr_slot_q <= '0;
					res_run_q  <= upd_run;
					res_slot_q <= upd_run ? pick_slot_q : '0;
					res_fin_q  <= upd_run && upd_fin;
					res_cs_q   <= upd_run && run_vld_q && !upd_same;
					if (upd_run) begin
						slice_q <= upd_same ? slice_inc : slice_first;
						if (upd_fin) begin
							finished_q  <= finished_q + CW'(1);
							res_total_q <= finished_q + CW'(1);
							run_vld_q   <= 1'b0;
							run_slot_q  <= '0;
						end else begin
							res_total_q <= finished_q;
							run_vld_q   <= 1'b1;
							run_slot_q  <= pick_slot_q;
						end
					end else begin
						res_total_q <= finished_q;
						run_vld_q   <= 1'b0;
						run_slot_q  <= '0;
						slice_q     <= '0;
					end
					state_q <= psp_pkg::ST_IDLE;
				end

				default: begin
					state_q <= psp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign arrived_slot   = arr_slot_q;
	assign run_valid      = res_run_q;
	assign run_slot       = res_slot_q;
	assign job_finished   = res_fin_q;
	assign context_switch = res_cs_q;
	assign finished_total = res_total_q;

	// checks
	`PSP_ASSERT_NOW(a_done_idle, done, !busy, "result shown while a tick is still at work")
	`PSP_ASSERT_NEXT(a_tick_busy, accept && command == psp_pkg::CMD_TICK, busy, "tick left busy low")
	`PSP_ASSERT_NOW(a_fin_le_arr, 1'b1, finished_q <= arrived_q, "more jobs finished than arrived")
	`PSP_ASSERT_NOW(a_ring_bound, 1'b1, ring_cnt_q <= CW'(psp_pkg::SLOTS), "ready ring count overflow")
	`PSP_ASSERT_NOW(a_run_slot, run_vld_q, CW'(run_slot_q) < arrived_q, "running slot never arrived")

endmodule
